/* rtl/wdm_pkg.sv */
// Shared types and constants for the wheel drive watchdog model.
// Used by the control, lane, merge and top-level modules; depends on nothing.
package wdm_pkg;

	localparam int WHEELS    = 4;
	localparam int WIDX_W    = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int CMD_PORTS = 4;
	localparam int VEL_W     = 32;
	localparam int POS_W     = 48;
	localparam int NS_W      = 32;
	localparam int AGE_W     = 34;
	localparam int CNT_W     = 17;
	localparam int TMO_W     = 32;
	localparam int CFG_W     = 32;

	localparam logic [AGE_W-1:0] AGE_MAX     = {AGE_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
	localparam logic [TMO_W-1:0] TIMEOUT_RST = 32'd100000000;
	localparam logic [CNT_W-1:0] LOSS_RST    = {CNT_W{1'b1}};

	// Rounding offset, divisor and 2^63 / divisor for the integration step.
	localparam logic [28:0] HALF_SEC = 29'd500000000;
	localparam logic [29:0] NS_PER_S = 30'd1000000000;
	localparam logic [33:0] RECIP    = 34'd9223372036;

	typedef enum logic [2:0] {
		ACT_CONNECT    = 3'd0,
		ACT_DISCONNECT = 3'd1,
		ACT_READ       = 3'd2,
		ACT_WRITE      = 3'd3,
		ACT_ENABLE     = 3'd4,
		ACT_STOP       = 3'd5,
		ACT_ADVANCE    = 3'd6
	} wdm_action_t;

	typedef enum logic {
		CFG_TIMEOUT = 1'b0,
		CFG_LOSS    = 1'b1
	} wdm_cfg_idx_t;

	typedef struct packed {
		logic link_ok;
		logic out_en;
		logic f_link;
		logic f_bad;
		logic f_time;
	} wdm_status_t;

	typedef struct packed {
		logic                              ok;
		logic                              rd;
		wdm_status_t                       st;
		logic [WHEELS-1:0][VEL_W-1:0]      speed;
	} wdm_item_t;

	typedef struct packed {
		logic integ;
		logic clr;
		logic neg;
	} wdm_lane_flags_t;

	typedef struct packed {
		wdm_lane_flags_t   flg;
		logic [VEL_W-1:0]  mag;
		logic [NS_W-1:0]   ns;
	} wdm_lane_req_t;

endpackage

/* rtl/wdm_ctrl.sv */
// Scalar drive state, configuration registers and the request pipeline
// that runs alongside the wheel lanes. Depends on wdm_pkg.
module wdm_ctrl (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic [2:0]                                   action,
	input  logic [wdm_pkg::VEL_W-1:0]                    cmd_vel_0,
	input  logic [wdm_pkg::VEL_W-1:0]                    cmd_vel_1,
	input  logic [wdm_pkg::VEL_W-1:0]                    cmd_vel_2,
	input  logic [wdm_pkg::VEL_W-1:0]                    cmd_vel_3,
	input  logic                                         command_not_finite,
	input  logic                                         enable_request,
	input  logic [wdm_pkg::NS_W-1:0]                     elapsed_ns,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic                                         cfg_index,
	input  logic [wdm_pkg::CFG_W-1:0]                    cfg_data,
	input  logic                                         take,
	output logic                                         adv,
	output wdm_pkg::wdm_lane_req_t [wdm_pkg::WHEELS-1:0] lane_req,
	output logic                                         fin_valid,
	output wdm_pkg::wdm_item_t                           fin_item
);
	import wdm_pkg::*;

	logic                          link_q, en_q;
	logic [WHEELS-1:0][VEL_W-1:0]  held_q, speed_q;
	logic [AGE_W-1:0]              age_q;
	logic [CNT_W-1:0]              cnt_q;
	wdm_status_t                   st_q;
	logic [TMO_W-1:0]              timeout_q;
	logic [CNT_W-1:0]              loss_q;

	logic                          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	wdm_item_t                     item_s1, item_s2, item_s3, item_s4, item_s5, item_s6;

	logic                          link_n, en_n;
	logic [WHEELS-1:0][VEL_W-1:0]  held_n, speed_n;
	logic [AGE_W-1:0]              age_n, age_sat;
	logic [AGE_W:0]                age_sum;
	logic [CNT_W-1:0]              cnt_n;
	wdm_status_t                   st_n;
	wdm_item_t                     item_n;
	logic                          ok, rd, integ, clr, do_time, late, acc;
	logic [CMD_PORTS-1:0][VEL_W-1:0] cmd_in;

	assign cfg_ready = 1'b1;
	assign adv       = !v_s6 || take;
	assign in_ready  = adv;
	assign acc       = in_valid && adv;
	assign cmd_in    = {cmd_vel_3, cmd_vel_2, cmd_vel_1, cmd_vel_0};

	always_comb begin
		link_n  = link_q;
		en_n    = en_q;
		held_n  = held_q;
		speed_n = speed_q;
		age_n   = age_q;
		cnt_n   = cnt_q;
		st_n    = st_q;
		ok      = 1'b0;
		rd      = 1'b0;
		clr     = 1'b0;
		integ   = 1'b0;
		do_time = 1'b0;
		age_sum = {1'b0, age_q} + (AGE_W+1)'(elapsed_ns);
		age_sat = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
		late    = age_sat > AGE_W'(timeout_q);
		case (action)
			ACT_CONNECT: begin
				if (timeout_q == '0) begin
					st_n.f_bad = 1'b1;
				end else begin
					held_n    = '0;
					speed_n   = '0;
					clr       = 1'b1;
					st_n      = '0;
					age_n     = AGE_W'(timeout_q);
					cnt_n     = '0;
					link_n    = 1'b1;
					en_n      = 1'b0;
					st_n.link_ok = 1'b1;
					ok        = 1'b1;
				end
			end
			ACT_DISCONNECT: begin
				en_n         = 1'b0;
				speed_n      = '0;
				st_n.out_en  = 1'b0;
				link_n       = 1'b0;
				st_n.link_ok = 1'b0;
				ok           = 1'b1;
			end
			ACT_READ: begin
				rd = 1'b1;
				if (!link_q) begin
					st_n.f_link = 1'b1;
				end else if (!loss_q[CNT_W-1] && cnt_q >= loss_q) begin
					// The simulated link drops once the read budget is spent.
					en_n         = 1'b0;
					speed_n      = '0;
					st_n.out_en  = 1'b0;
					link_n       = 1'b0;
					st_n.link_ok = 1'b0;
					st_n.f_link  = 1'b1;
				end else begin
					do_time = 1'b1;
					if (cnt_q != CNT_MAX) begin
						cnt_n = cnt_q + 1'b1;
					end
					ok = 1'b1;
				end
			end
			ACT_WRITE: begin
				if (!link_q) begin
					st_n.f_link = 1'b1;
				end else if (command_not_finite) begin
					st_n.f_bad  = 1'b1;
					speed_n     = '0;
					st_n.out_en = en_q;
				end else begin
					age_n       = '0;
					st_n.f_time = 1'b0;
					if (en_q) begin
						for (int w = 0; w < WHEELS; w++) begin
							held_n[w] = (w < CMD_PORTS) ? cmd_in[w % CMD_PORTS] : '0;
						end
					end else begin
						held_n      = '0;
						speed_n     = '0;
						st_n.out_en = 1'b0;
					end
					ok = 1'b1;
				end
			end
			ACT_ENABLE: begin
				if (!link_q) begin
					st_n.f_link = 1'b1;
				end else begin
					en_n        = enable_request;
					st_n.out_en = enable_request;
					if (!enable_request) begin
						held_n  = '0;
						speed_n = '0;
					end
					ok = 1'b1;
				end
			end
			ACT_STOP: begin
				if (!link_q) begin
					st_n.f_link = 1'b1;
				end else begin
					held_n      = '0;
					speed_n     = '0;
					st_n.out_en = en_q;
					ok          = 1'b1;
				end
			end
			ACT_ADVANCE: begin
				do_time = link_q && (elapsed_ns != '0);
				ok      = 1'b1;
			end
			default: begin
			end
		endcase
		// Elapsed time ages the command and either stops or moves the wheels.
		if (do_time) begin
			age_n       = age_sat;
			st_n.f_time = late;
			if (!en_q || late) begin
				speed_n     = '0;
				st_n.out_en = en_q;
			end else begin
				speed_n      = held_q;
				integ        = 1'b1;
				st_n.link_ok = 1'b1;
				st_n.out_en  = 1'b1;
			end
		end
		item_n.ok    = ok;
		item_n.rd    = rd;
		item_n.st    = st_n;
		item_n.speed = speed_n;
	end

	always_comb begin
		for (int w = 0; w < WHEELS; w++) begin
			lane_req[w].flg.integ = acc && integ;
			lane_req[w].flg.clr   = acc && clr;
			lane_req[w].flg.neg   = held_q[w][VEL_W-1];
			lane_req[w].mag       = held_q[w][VEL_W-1] ? (~held_q[w] + 1'b1) : held_q[w];
			lane_req[w].ns        = elapsed_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			loss_q    <= LOSS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (wdm_cfg_idx_t'(cfg_index))
				CFG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				CFG_LOSS:    loss_q    <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q  <= 1'b0;
			en_q    <= 1'b0;
			held_q  <= '0;
			speed_q <= '0;
			age_q   <= '0;
			cnt_q   <= '0;
			st_q    <= '0;
		end else if (acc) begin
			link_q  <= link_n;
			en_q    <= en_n;
			held_q  <= held_n;
			speed_q <= speed_n;
			age_q   <= age_n;
			cnt_q   <= cnt_n;
			st_q    <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_n;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= item_s3;
			item_s5 <= item_s4;
			item_s6 <= item_s5;
		end
	end

	assign fin_valid = v_s6;
	assign fin_item  = item_s6;

endmodule

/* rtl/wdm_lane.sv */
// One wheel lane: velocity times elapsed time, rounded division by 1e9 via a
// reciprocal estimate with correction, and the wrapping position register.
// Depends on wdm_pkg.
module wdm_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  wdm_pkg::wdm_lane_req_t         req,
	output logic [wdm_pkg::POS_W-1:0]      pos
);
	import wdm_pkg::*;

	wdm_lane_flags_t   flg_s1, flg_s2, flg_s3, flg_s4, flg_s5, flg_s6;
	logic [VEL_W-1:0]  mag_s1;
	logic [NS_W-1:0]   ns_s1;
	logic [63:0]       p_s2, n_s3, n_s4;
	logic [33:0]       qe_s4, qe_s5, q_s6;
	logic [32:0]       r_s5;
	logic [66:0]       est;
	logic [63:0]       back;
	logic [2:0]        fix;
	logic [POS_W-1:0]  angle_q, angle_nx, delta;

	// The estimate never exceeds the quotient and trails it by at most four.
	assign est  = 67'(n_s3[63:31]) * 67'(RECIP);
	assign back = 64'(qe_s4) * 64'(NS_PER_S);

	always_comb begin
		fix = '0;
		for (int k = 1; k <= 4; k++) begin
			if (r_s5 >= 33'(k) * 33'(NS_PER_S)) begin
				fix = fix + 3'd1;
			end
		end
	end

	always_comb begin
		delta = flg_s6.neg ? (~POS_W'(q_s6) + 1'b1) : POS_W'(q_s6);
		if (flg_s6.clr) begin
			angle_nx = '0;
		end else if (flg_s6.integ) begin
			angle_nx = angle_q + delta;
		end else begin
			angle_nx = angle_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_s1  <= '0;
			flg_s2  <= '0;
			flg_s3  <= '0;
			flg_s4  <= '0;
			flg_s5  <= '0;
			flg_s6  <= '0;
			angle_q <= '0;
		end else if (adv) begin
			flg_s1  <= req.flg;
			flg_s2  <= flg_s1;
			flg_s3  <= flg_s2;
			flg_s4  <= flg_s3;
			flg_s5  <= flg_s4;
			flg_s6  <= flg_s5;
			angle_q <= angle_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= req.mag;
			ns_s1  <= req.ns;
			p_s2   <= 64'(mag_s1) * 64'(ns_s1);
			n_s3   <= p_s2 + 64'(HALF_SEC);
			qe_s4  <= est[65:32];
			n_s4   <= n_s3;
			r_s5   <= 33'(n_s4 - back);
			qe_s5  <= qe_s4;
			q_s6   <= qe_s5 + 34'(fix);
		end
	end

	assign pos = angle_nx;

endmodule

/* rtl/wdm_merge.sv */
// Result buffer that gathers the lane positions with the item status and
// hands out one result per cycle while out_ready is high. Depends on wdm_pkg.
module wdm_merge (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      ld,
	input  wdm_pkg::wdm_item_t                        item,
	input  logic [wdm_pkg::WHEELS-1:0][wdm_pkg::POS_W-1:0] pos,
	output logic                                      take,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic                                      success,
	output logic [1:0]                                wheel_index,
	output logic [wdm_pkg::VEL_W-1:0]                 wheel_velocity,
	output logic [wdm_pkg::POS_W-1:0]                 wheel_position,
	output logic                                      link_ok,
	output logic                                      outputs_enabled,
	output logic                                      fault_link_lost,
	output logic                                      fault_bad_command,
	output logic                                      fault_timed_out,
	output logic                                      last
);
	import wdm_pkg::*;

	logic                          busy_q;
	logic [WIDX_W-1:0]             idx_q;
	wdm_item_t                     item_q;
	logic [WHEELS-1:0][POS_W-1:0]  pos_q;
	logic                          idx_last;

	assign idx_last = !item_q.rd || (idx_q == WIDX_W'(WHEELS - 1));
	assign take     = !busy_q || (out_ready && idx_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (ld) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (idx_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			item_q <= item;
			pos_q  <= pos;
		end
	end

	assign out_valid         = busy_q;
	assign success           = item_q.ok;
	assign wheel_index       = item_q.rd ? 2'(idx_q) : 2'd0;
	assign wheel_velocity    = item_q.rd ? item_q.speed[idx_q] : '0;
	assign wheel_position    = item_q.rd ? pos_q[idx_q] : '0;
	assign link_ok           = item_q.st.link_ok;
	assign outputs_enabled   = item_q.st.out_en;
	assign fault_link_lost   = item_q.st.f_link;
	assign fault_bad_command = item_q.st.f_bad;
	assign fault_timed_out   = item_q.st.f_time;
	assign last              = idx_last;

endmodule

/* rtl/wheel_drive_watchdog_model.sv */
// Four-wheel drive model with a command watchdog. When a request is taken,
// the link, enable, command, age, read count and fault state update on the
// spot, so requests may arrive in every cycle unless a finished result waits
// on the busy result port. Each wheel has its own lane that multiplies velocity
// by elapsed time and divides by 1e9 over six pipeline stages. The result port
// then sets the pace: one result per request, except a read, which delivers
// one result per wheel, four in this build.
// Depends on wdm_pkg, wdm_ctrl, wdm_lane and wdm_merge.
module wheel_drive_watchdog_model (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    action,
	input  logic [wdm_pkg::VEL_W-1:0]     cmd_vel_0,
	input  logic [wdm_pkg::VEL_W-1:0]     cmd_vel_1,
	input  logic [wdm_pkg::VEL_W-1:0]     cmd_vel_2,
	input  logic [wdm_pkg::VEL_W-1:0]     cmd_vel_3,
	input  logic                          command_not_finite,
	input  logic                          enable_request,
	input  logic [wdm_pkg::NS_W-1:0]      elapsed_ns,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [wdm_pkg::CFG_W-1:0]     cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          success,
	output logic [1:0]                    wheel_index,
	output logic [wdm_pkg::VEL_W-1:0]     wheel_velocity,
	output logic [wdm_pkg::POS_W-1:0]     wheel_position,
	output logic                          link_ok,
	output logic                          outputs_enabled,
	output logic                          fault_link_lost,
	output logic                          fault_bad_command,
	output logic                          fault_timed_out,
	output logic                          last
);
	import wdm_pkg::*;

	logic                          take, adv, fin_valid;
	wdm_item_t                     fin_item;
	wdm_lane_req_t [WHEELS-1:0]    lane_req;
	logic [WHEELS-1:0][POS_W-1:0]  pos;

	wdm_ctrl u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.action             (action),
		.cmd_vel_0          (cmd_vel_0),
		.cmd_vel_1          (cmd_vel_1),
		.cmd_vel_2          (cmd_vel_2),
		.cmd_vel_3          (cmd_vel_3),
		.command_not_finite (command_not_finite),
		.enable_request     (enable_request),
		.elapsed_ns         (elapsed_ns),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.take               (take),
		.adv                (adv),
		.lane_req           (lane_req),
		.fin_valid          (fin_valid),
		.fin_item           (fin_item)
	);

	for (genvar w = 0; w < WHEELS; w++) begin : g_lane
		wdm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.req    (lane_req[w]),
			.pos    (pos[w])
		);
	end

	wdm_merge u_merge (
		.clk               (clk),
		.arst_n            (arst_n),
		.ld                (adv && fin_valid),
		.item              (fin_item),
		.pos               (pos),
		.take              (take),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.success           (success),
		.wheel_index       (wheel_index),
		.wheel_velocity    (wheel_velocity),
		.wheel_position    (wheel_position),
		.link_ok           (link_ok),
		.outputs_enabled   (outputs_enabled),
		.fault_link_lost   (fault_link_lost),
		.fault_bad_command (fault_bad_command),
		.fault_timed_out   (fault_timed_out),
		.last              (last)
	);

	// The pipeline only holds requests back while a result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled without a pending result");

	// A request with more results to deliver keeps the output valid.
	a_burst_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("result burst broken before its last result");

	// Per-wheel results of a read come in wheel order.
	a_wheel_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> wheel_index == 2'($past(wheel_index) + 2'd1))
		else $error("wheel results out of order");

endmodule

/* sim/tb_wheel_drive_watchdog_model.sv */
`timescale 1ns / 1ps
// Self-checking testbench for wheel_drive_watchdog_model. A directed table and
// random requests are checked against a predictor of the drive state kept here.
// Depends on wdm_pkg and the wheel_drive_watchdog_model RTL.
module tb_wheel_drive_watchdog_model;
	import wdm_pkg::*;

	localparam int          SETTLE_CYCLES = 12;
	localparam int          LONG_HOLD     = 300;
	localparam int          PHASE_ITEMS   = 90;
	localparam logic [63:0] ROUND_HALF    = 64'd500000000;
	localparam logic [63:0] ONE_SECOND_NS = 64'd1000000000;

	typedef struct packed {
		wdm_action_t                 act;
		logic [WHEELS-1:0][VEL_W-1:0] cmd;
		logic                        not_finite;
		logic                        en_req;
		logic [NS_W-1:0]             ns;
	} drive_req_t;

	typedef struct packed {
		logic             success;
		logic [1:0]       widx;
		logic [VEL_W-1:0] vel;
		logic [POS_W-1:0] pos;
		logic             link_ok;
		logic             out_en;
		logic             f_link;
		logic             f_bad;
		logic             f_time;
		logic             last;
	} wheel_report_t;

	typedef enum logic {
		ROW_REQ,
		ROW_REG
	} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		drive_req_t    req;
		bit            typed;
		wheel_report_t want;
		wdm_cfg_idx_t  reg_idx;
		logic [31:0]   reg_data;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [2:0]          action;
	logic [VEL_W-1:0]    cmd_vel_0;
	logic [VEL_W-1:0]    cmd_vel_1;
	logic [VEL_W-1:0]    cmd_vel_2;
	logic [VEL_W-1:0]    cmd_vel_3;
	logic                command_not_finite;
	logic                enable_request;
	logic [NS_W-1:0]     elapsed_ns;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                out_valid;
	logic                out_ready;
	logic                success;
	logic [1:0]          wheel_index;
	logic [VEL_W-1:0]    wheel_velocity;
	logic [POS_W-1:0]    wheel_position;
	logic                link_ok;
	logic                outputs_enabled;
	logic                fault_link_lost;
	logic                fault_bad_command;
	logic                fault_timed_out;
	logic                last;

	// Predicted drive state and register copies.
	logic [TMO_W-1:0]    watchdog_limit = TIMEOUT_RST;
	logic [CNT_W-1:0]    loss_limit     = LOSS_RST;
	logic                link_up        = 1'b0;
	logic                drive_en       = 1'b0;
	logic [VEL_W-1:0]    held_cmd [WHEELS]    = '{default: '0};
	logic [VEL_W-1:0]    wheel_speed [WHEELS] = '{default: '0};
	logic [POS_W-1:0]    wheel_angle [WHEELS] = '{default: '0};
	logic [63:0]         age_ns         = '0;
	logic [CNT_W-1:0]    read_count     = '0;
	logic                st_link_ok     = 1'b0;
	logic                st_out_en      = 1'b0;
	logic                f_link         = 1'b0;
	logic                f_bad          = 1'b0;
	logic                f_time         = 1'b0;

	wheel_report_t       fresh[$];
	wheel_report_t       pending_reports[$];

	int                  send_idle_pct  = 0;
	int                  recv_stall_pct = 0;
	bit                  hold_now       = 1'b0;
	int                  fail_count     = 0;
	int                  items_sent     = 0;
	int                  results_seen   = 0;
	int                  regs_written   = 0;

	wheel_drive_watchdog_model DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.action             (action),
		.cmd_vel_0          (cmd_vel_0),
		.cmd_vel_1          (cmd_vel_1),
		.cmd_vel_2          (cmd_vel_2),
		.cmd_vel_3          (cmd_vel_3),
		.command_not_finite (command_not_finite),
		.enable_request     (enable_request),
		.elapsed_ns         (elapsed_ns),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.success            (success),
		.wheel_index        (wheel_index),
		.wheel_velocity     (wheel_velocity),
		.wheel_position     (wheel_position),
		.link_ok            (link_ok),
		.outputs_enabled    (outputs_enabled),
		.fault_link_lost    (fault_link_lost),
		.fault_bad_command  (fault_bad_command),
		.fault_timed_out    (fault_timed_out),
		.last               (last)
	);

	always #4 clk = ~clk;

	function automatic void zero_speeds();
		foreach (wheel_speed[w]) wheel_speed[w] = '0;
		st_out_en = drive_en;
	endfunction

	function automatic void clear_held();
		foreach (held_cmd[w]) held_cmd[w] = '0;
	endfunction

	// Ages the last command and, while the drive runs, moves each wheel by
	// velocity times elapsed seconds, rounded half away from zero.
	function automatic void integrate(input logic [NS_W-1:0] ns);
		logic [VEL_W-1:0] mag32;
		logic [63:0]      mag;
		logic [63:0]      step_q;
		logic             neg;
		logic             late;
		age_ns = age_ns + {32'b0, ns};
		if (age_ns > 64'(AGE_MAX))
			age_ns = 64'(AGE_MAX);
		late = age_ns > {32'b0, watchdog_limit};
		f_time = late;
		if (!drive_en || late) begin
			zero_speeds();
			return;
		end
		foreach (held_cmd[w]) begin
			neg = held_cmd[w][VEL_W-1];
			mag32 = neg ? (~held_cmd[w] + 32'd1) : held_cmd[w];
			mag = {32'b0, mag32};
			step_q = (mag * {32'b0, ns} + ROUND_HALF) / ONE_SECOND_NS;
			if (neg)
				wheel_angle[w] = wheel_angle[w] - step_q[POS_W-1:0];
			else
				wheel_angle[w] = wheel_angle[w] + step_q[POS_W-1:0];
			wheel_speed[w] = held_cmd[w];
		end
		st_link_ok = 1'b1;
		st_out_en = 1'b1;
	endfunction

	function automatic wheel_report_t report(input logic ok, input logic [1:0] idx,
			input logic [VEL_W-1:0] vel, input logic [POS_W-1:0] pos, input logic fin);
		wheel_report_t rep;
		rep = '{ok, idx, vel, pos, st_link_ok, st_out_en, f_link, f_bad, f_time, fin};
		return rep;
	endfunction

	// Advances the predicted state by one request and leaves its results in fresh.
	function automatic void predict_reports(input drive_req_t r);
		logic ok;
		logic loss_on;
		ok = 1'b0;
		fresh.delete();
		case (r.act)
			ACT_CONNECT: begin
				if (watchdog_limit == '0) begin
					f_bad = 1'b1;
				end else begin
					clear_held();
					foreach (wheel_speed[w]) wheel_speed[w] = '0;
					foreach (wheel_angle[w]) wheel_angle[w] = '0;
					{f_link, f_bad, f_time} = '0;
					age_ns = {32'b0, watchdog_limit};
					read_count = '0;
					link_up = 1'b1;
					drive_en = 1'b0;
					st_out_en = 1'b0;
					st_link_ok = 1'b1;
					ok = 1'b1;
				end
			end
			ACT_DISCONNECT: begin
				drive_en = 1'b0;
				zero_speeds();
				link_up = 1'b0;
				st_link_ok = 1'b0;
				ok = 1'b1;
			end
			ACT_READ: begin
				loss_on = !loss_limit[CNT_W-1];
				if (!link_up) begin
					f_link = 1'b1;
				end else if (loss_on && read_count >= loss_limit) begin
					drive_en = 1'b0;
					zero_speeds();
					link_up = 1'b0;
					st_link_ok = 1'b0;
					f_link = 1'b1;
				end else begin
					integrate(r.ns);
					if (read_count != CNT_MAX)
						read_count = read_count + 1'b1;
					ok = 1'b1;
				end
				for (int w = 0; w < WHEELS; w++)
					fresh.push_back(report(ok, 2'(w), wheel_speed[w], wheel_angle[w],
						w == WHEELS - 1));
			end
			ACT_WRITE: begin
				if (!link_up) begin
					f_link = 1'b1;
				end else if (r.not_finite) begin
					f_bad = 1'b1;
					zero_speeds();
				end else begin
					age_ns = '0;
					f_time = 1'b0;
					if (drive_en) begin
						for (int w = 0; w < WHEELS; w++)
							held_cmd[w] = r.cmd[w];
					end else begin
						clear_held();
						zero_speeds();
					end
					ok = 1'b1;
				end
			end
			ACT_ENABLE: begin
				if (!link_up) begin
					f_link = 1'b1;
				end else begin
					drive_en = r.en_req;
					st_out_en = r.en_req;
					if (!r.en_req) begin
						clear_held();
						zero_speeds();
					end
					ok = 1'b1;
				end
			end
			ACT_STOP: begin
				if (!link_up) begin
					f_link = 1'b1;
				end else begin
					clear_held();
					zero_speeds();
					ok = 1'b1;
				end
			end
			ACT_ADVANCE: begin
				if (link_up && r.ns != '0)
					integrate(r.ns);
				ok = 1'b1;
			end
			default: ;
		endcase
		if (r.act != ACT_READ)
			fresh.push_back(report(ok, 2'd0, '0, '0, 1'b1));
	endfunction

	function automatic drive_req_t mk(input wdm_action_t a, input logic [31:0] c0, c1, c2, c3,
			input logic nf, input logic en, input logic [31:0] ns);
		drive_req_t r;
		r.act = a;
		r.cmd = {c3, c2, c1, c0};
		r.not_finite = nf;
		r.en_req = en;
		r.ns = ns;
		return r;
	endfunction

	// Expected single result of a non-read request with the given status bits.
	function automatic wheel_report_t brief(input logic ok, link, oen, fl, fb, ft);
		wheel_report_t rep;
		rep = '{ok, 2'd0, '0, '0, link, oen, fl, fb, ft, 1'b1};
		return rep;
	endfunction

	function automatic plan_row_t req_row(input drive_req_t r);
		plan_row_t row;
		row = '{ROW_REQ, r, 1'b0, '0, CFG_TIMEOUT, '0};
		return row;
	endfunction

	function automatic plan_row_t typed_row(input drive_req_t r, input wheel_report_t want);
		plan_row_t row;
		row = '{ROW_REQ, r, 1'b1, want, CFG_TIMEOUT, '0};
		return row;
	endfunction

	function automatic plan_row_t reg_row(input wdm_cfg_idx_t idx, input logic [31:0] data);
		plan_row_t row;
		row = '{ROW_REG, '0, 1'b0, '0, idx, data};
		return row;
	endfunction

	function automatic logic [VEL_W-1:0] random_velocity();
		logic [VEL_W-1:0] v;
		case ($urandom_range(7))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2, 3: v = 32'($urandom_range(262144));
			4: v = -32'($urandom_range(262144));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Mostly well-formed sessions: a dropped link is usually reconnected, and
	// reads and command writes dominate once it is up.
	function automatic drive_req_t random_req();
		drive_req_t r;
		int roll;
		roll = $urandom_range(99);
		if (!link_up && $urandom_range(99) < 60)
			r.act = ACT_CONNECT;
		else if (roll < 6)
			r.act = ACT_CONNECT;
		else if (roll < 10)
			r.act = ACT_DISCONNECT;
		else if (roll < 40)
			r.act = ACT_READ;
		else if (roll < 62)
			r.act = ACT_WRITE;
		else if (roll < 74)
			r.act = ACT_ENABLE;
		else if (roll < 79)
			r.act = ACT_STOP;
		else
			r.act = ACT_ADVANCE;
		for (int w = 0; w < WHEELS; w++)
			r.cmd[w] = random_velocity();
		r.not_finite = ($urandom_range(9) == 0);
		r.en_req = ($urandom_range(4) != 0);
		case ($urandom_range(9))
			0: r.ns = '0;
			1: r.ns = '1;
			2: r.ns = $urandom;
			3, 4, 5: r.ns = $urandom_range(2000000);
			default: r.ns = $urandom_range(40000000);
		endcase
		return r;
	endfunction

	function automatic string describe(input wheel_report_t r);
		return $sformatf("ok=%0b wheel=%0d vel=%h pos=%h link=%0b en=%0b lost=%0b bad=%0b late=%0b last=%0b",
			r.success, r.widx, r.vel, r.pos, r.link_ok, r.out_en, r.f_link, r.f_bad,
			r.f_time, r.last);
	endfunction

	// Drops the request valid and waits until every expected result is back.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic offer(input drive_req_t r);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		cmd_vel_0 <= r.cmd[0];
		cmd_vel_1 <= r.cmd[1];
		cmd_vel_2 <= r.cmd[2];
		cmd_vel_3 <= r.cmd[3];
		command_not_finite <= r.not_finite;
		enable_request <= r.en_req;
		elapsed_ns <= r.ns;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic run_row(input plan_row_t row);
		if (row.kind == ROW_REG) begin
			settle();
			cfg_valid <= 1'b1;
			cfg_index <= row.reg_idx;
			cfg_data <= row.reg_data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cfg_valid <= 1'b0;
			if (row.reg_idx == CFG_TIMEOUT)
				watchdog_limit = row.reg_data;
			else
				loss_limit = row.reg_data[CNT_W-1:0];
			regs_written++;
		end else begin
			predict_reports(row.req);
			if (row.typed)
				pending_reports.push_back(row.want);
			else
				foreach (fresh[k]) pending_reports.push_back(fresh[k]);
			offer(row.req);
		end
	endtask

	initial begin : receiver
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_now) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
				hold_now = 1'b0;
			end else begin
				out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		wheel_report_t seen;
		wheel_report_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			seen = '{success, wheel_index, wheel_velocity, wheel_position, link_ok,
				outputs_enabled, fault_link_lost, fault_bad_command, fault_timed_out, last};
			results_seen++;
			if (pending_reports.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, got %s", $time, describe(seen));
			end else begin
				want = pending_reports.pop_front();
				if (seen !== want) begin
					fail_count++;
					$display("%0t: mismatch, expected %s", $time, describe(want));
					$display("%0t:           actual   %s", $time, describe(seen));
				end
			end
		end
	end

	initial begin : run_limit
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		plan_row_t plan[$];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_CONNECT;
		cmd_vel_0 <= '0;
		cmd_vel_1 <= '0;
		cmd_vel_2 <= '0;
		cmd_vel_3 <= '0;
		command_not_finite <= 1'b0;
		enable_request <= 1'b0;
		elapsed_ns <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= '0;

		// With the link down writes and reads fail and set the sticky link fault; an advance still succeeds.
		plan.push_back(typed_row(mk(ACT_WRITE, 1, 2, 3, 4, 1'b0, 1'b0, 0),
			brief(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)));
		plan.push_back(req_row(mk(ACT_READ, 0, 0, 0, 0, 1'b0, 1'b0, 5)));
		plan.push_back(typed_row(mk(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, '1),
			brief(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)));
		plan.push_back(typed_row(mk(ACT_CONNECT, 0, 0, 0, 0, 1'b0, 1'b0, 0),
			brief(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)));
		plan.push_back(typed_row(mk(ACT_ENABLE, 0, 0, 0, 0, 1'b0, 1'b1, 0),
			brief(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)));
		plan.push_back(typed_row(mk(ACT_WRITE, '1, '1, '1, '1, 1'b1, 1'b0, 0),
			brief(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0)));
		plan.push_back(typed_row(mk(ACT_WRITE, 32'h7FFF_FFFF, 32'h8000_0000, 1, '1,
			1'b0, 1'b0, 0), brief(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0)));
		plan.push_back(req_row(mk(ACT_READ, 0, 0, 0, 0, 1'b0, 1'b0, 1000000)));
		plan.push_back(req_row(mk(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 0)));
		// The age lands exactly on the limit, then one more nanosecond trips it.
		plan.push_back(req_row(mk(ACT_READ, 0, 0, 0, 0, 1'b0, 1'b0, 99000000)));
		plan.push_back(req_row(mk(ACT_READ, 0, 0, 0, 0, 1'b0, 1'b0, 1)));
		// Ten units over 50 ms is an exact half step in both directions.
		plan.push_back(req_row(mk(ACT_WRITE, 10, 32'hFFFF_FFF6, 32'h0001_0000, 32'h8000_0000,
			1'b0, 1'b0, 0)));
		plan.push_back(req_row(mk(ACT_ADVANCE, 0, 0, 0, 0, 1'b0, 1'b0, 50000000)));
		plan.push_back(req_row(mk(ACT_STOP, 0, 0, 0, 0, 1'b0, 1'b0, 0)));
		plan.push_back(req_row(mk(ACT_ENABLE, 0, 0, 0, 0, 1'b0, 1'b0, 0)));
		plan.push_back(req_row(mk(ACT_WRITE, 5, 6, 7, 8, 1'b0, 1'b0, 0)));
		plan.push_back(req_row(mk(ACT_DISCONNECT, 0, 0, 0, 0, 1'b0, 1'b0, 0)));
		plan.push_back(req_row(mk(ACT_STOP, 0, 0, 0, 0, 1'b0, 1'b0, 0)));
		plan.push_back(reg_row(CFG_TIMEOUT, 32'd0));
		plan.push_back(req_row(mk(ACT_CONNECT, 0, 0, 0, 0, 1'b0, 1'b0, 0)));
		plan.push_back(reg_row(CFG_TIMEOUT, 32'hFFFF_FFFF));
		plan.push_back(reg_row(CFG_LOSS, 32'd0));
		plan.push_back(typed_row(mk(ACT_CONNECT, 0, 0, 0, 0, 1'b0, 1'b0, 0),
			brief(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)));
		plan.push_back(req_row(mk(ACT_READ, 0, 0, 0, 0, 1'b0, 1'b0, '1)));
		plan.push_back(reg_row(CFG_LOSS, 32'd1));
		plan.push_back(req_row(mk(ACT_CONNECT, 0, 0, 0, 0, 1'b0, 1'b0, 0)));
		plan.push_back(typed_row(mk(ACT_ENABLE, 0, 0, 0, 0, 1'b0, 1'b1, 0),
			brief(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)));
		plan.push_back(req_row(mk(ACT_READ, 0, 0, 0, 0, 1'b0, 1'b0, 0)));
		plan.push_back(req_row(mk(ACT_READ, 0, 0, 0, 0, 1'b0, 1'b0, 7)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) run_row(plan[i]);

		send_idle_pct = 84;
		run_row(reg_row(CFG_TIMEOUT, TIMEOUT_RST));
		run_row(reg_row(CFG_LOSS, 32'hFFFF_FFFF));
		repeat (PHASE_ITEMS) run_row(req_row(random_req()));

		send_idle_pct = 0;
		recv_stall_pct = 84;
		run_row(reg_row(CFG_TIMEOUT, 32'hFFFF_FFFF));
		run_row(reg_row(CFG_LOSS, 32'd65535));
		repeat (PHASE_ITEMS) run_row(req_row(random_req()));

		send_idle_pct = 16;
		recv_stall_pct = 16;
		run_row(reg_row(CFG_TIMEOUT, 32'($urandom_range(20000000, 1))));
		run_row(reg_row(CFG_LOSS, 32'($urandom_range(12, 2))));
		repeat (PHASE_ITEMS) run_row(req_row(random_req()));

		// Back-to-back requests against a long output stall fill the block.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_row(reg_row(CFG_TIMEOUT, TIMEOUT_RST));
		run_row(reg_row(CFG_LOSS, 32'hFFFF_0000));
		hold_now = 1'b1;
		repeat (PHASE_ITEMS) run_row(req_row(random_req()));

		settle();
		$display("Ran %0d drive requests giving %0d results and %0d register writes,",
			items_sent, results_seen, regs_written);
		$display("over watchdog limits from zero to full scale and link loss off, short and long.");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
